// ----- sv/sorted_table_linear_interpolator_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stli: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define STLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stli: next-cycle property violated");

`endif

// ----- sv/stli_pkg.sv -----
// ----------------------------------------------------------------------------
// stli_pkg
// Shared types and constants of the sorted table linear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stli_pkg;

  // Default table depth.
  localparam int DEPTH_DEF = 64;

  // Command codes; the last one is reserved and does nothing.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_INTERP = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  // Steps of the shared multiply and divide unit.
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 33;

  // One stored point.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } stli_point_t;

endpackage

// ----- sv/stli_table.sv -----
// ----------------------------------------------------------------------------
// stli_table
// Point memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stli_table
  import stli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output stli_point_t   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  stli_point_t   wr_data
);

  stli_point_t mem [DEPTH];
  stli_point_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/stli_muldiv.sv -----
// ----------------------------------------------------------------------------
// stli_muldiv
// Iterative unit computing (mag * num) / den with one shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stli_muldiv
  import stli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] mag,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [32:0] quo
);

  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic [32:0] den_r, den_nxt;
  logic [33:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] sh_r, sh_nxt;
  logic [32:0] q_r, q_nxt;
  logic [34:0] add_a, add_b, add_s;
  logic        add_sub;
  logic [33:0] trial;

  // Shared adder: add for the multiply, subtract for the divide.
  assign trial = {rem_r[32:0], sh_r[32]};
  always_comb begin
    if (div_r) begin
      add_a   = {1'b0, trial};
      add_b   = {2'b00, den_r};
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, hi_r};
      add_b   = lo_r[0] ? {2'b00, mag_r} : 35'd0;
      add_sub = 1'b0;
    end
    add_s = add_a + (add_sub ? ~add_b : add_b) + {34'd0, add_sub};
  end

  // Sequencer: shift-add multiply, then restoring divide.
  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    den_nxt  = den_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = 1'b0;
      cnt_nxt  = '0;
      mag_nxt  = mag;
      den_nxt  = den;
      hi_nxt   = '0;
      lo_nxt   = num;
      q_nxt    = '0;
    end else if (busy_r && !div_r) begin
      hi_nxt  = {1'b0, add_s[33:1]};
      lo_nxt  = {add_s[0], lo_r[31:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(MUL_STEPS - 1)) begin
        // The product is {hi[31:0], lo}; its top bits seed the remainder.
        div_nxt = 1'b1;
        cnt_nxt = '0;
        rem_nxt = {3'b000, hi_nxt[31:1]};
        sh_nxt  = {hi_nxt[0], lo_nxt};
      end
    end else if (busy_r) begin
      if (!add_s[34]) begin
        rem_nxt = add_s[33:0];
      end else begin
        rem_nxt = trial;
      end
      q_nxt   = {q_r[31:0], ~add_s[34]};
      sh_nxt  = {sh_r[31:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        div_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      div_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      div_r  <= div_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    den_r <= den_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- sv/sorted_table_linear_interpolator.sv -----
// Clear and unused commands, a full insert and an empty query report from the dispatch
// state. The table is scanned through the single memory read port; an insert then moves
// the entries above its place up by a place, and a query may then run the 65-step
// multiply and divide unit. One item is worked on at a time while busy is high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the table; the memory itself is not cleared.
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator
// Sorted (x, y) table with insert, clear and interpolating query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_linear_interpolator
  import stli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_SHRD = 4'd4;
  localparam logic [3:0] S_SHWR = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] px_r, px_nxt;
  logic signed [31:0] py_r, py_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] x0_r, x0_nxt;
  logic signed [31:0] y0_r, y0_nxt;
  logic signed [32:0] dy_r, dy_nxt;
  logic [31:0]        num_r, num_nxt;
  logic [32:0]        den_r, den_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [2:0]         ost_r, ost_nxt;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  stli_point_t   rd_data, wr_data;
  logic [CW-1:0] idx_dec;
  logic          md_start, md_done;
  logic [32:0]   md_mag, md_quo;
  logic signed [32:0] diff_x;

  stli_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  stli_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(md_start),
    .mag  (md_mag),
    .num  (num_r),
    .den  (den_r),
    .done (md_done),
    .quo  (md_quo)
  );

  assign idx_dec = idx_r - CW'(1);
  assign md_mag  = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign diff_x  = 33'(rd_data.x) - 33'(x0_r);

  // Command sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    x0_nxt    = x0_r;
    y0_nxt    = y0_r;
    dy_nxt    = dy_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    ov_nxt    = 1'b0;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = rd_data;
    md_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          px_nxt    = in_point_x;
          py_nxt    = in_point_y;
          idx_nxt   = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        // Commands that finish at once report here.
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        oval_nxt  = '0;
        ost_nxt   = ST_DONE;
        case (cmd_r)
          CMD_CLEAR: begin
            count_nxt = '0;
          end
          CMD_INSERT: begin
            if (count_r >= CW'(DEPTH)) begin
              ost_nxt = ST_FULL;
            end else begin
              ov_nxt    = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          CMD_QUERY: begin
            if (count_r == '0) begin
              ost_nxt = ST_EMPTY;
            end else begin
              ov_nxt    = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            ost_nxt = ST_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          if (cmd_r == CMD_INSERT) begin
            pos_nxt   = idx_r;
            state_nxt = S_SHRD;
          end else begin
            ov_nxt    = 1'b1;
            oval_nxt  = '0;
            ost_nxt   = ST_RANGE;
            state_nxt = S_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (cmd_r == CMD_INSERT) begin
          // The new point goes before the first entry with a larger x.
          if (rd_data.x > px_r) begin
            pos_nxt   = idx_r;
            idx_nxt   = count_r;
            state_nxt = S_SHRD;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_SCAN;
          end
        end else if (rd_data.x == px_r) begin
          ov_nxt    = 1'b1;
          oval_nxt  = rd_data.y;
          ost_nxt   = ST_MATCH;
          state_nxt = S_IDLE;
        end else if (rd_data.x > px_r) begin
          if (idx_r == '0) begin
            ov_nxt    = 1'b1;
            oval_nxt  = '0;
            ost_nxt   = ST_RANGE;
            state_nxt = S_IDLE;
          end else begin
            dy_nxt    = 33'(rd_data.y) - 33'(y0_r);
            num_nxt   = 32'(px_r - x0_r);
            den_nxt   = 33'(diff_x);
            state_nxt = S_PREP;
          end
        end else begin
          x0_nxt    = rd_data.x;
          y0_nxt    = rd_data.y;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SHRD: begin
        if (idx_r == pos_r) begin
          wr_en     = 1'b1;
          wr_data   = '{x: px_r, y: py_r};
          count_nxt = count_r + CW'(1);
          ov_nxt    = 1'b1;
          oval_nxt  = '0;
          ost_nxt   = ST_DONE;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        // Move one entry up by a place.
        wr_en     = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_SHRD;
      end
      S_PREP: begin
        md_start  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (md_done) begin
          ov_nxt    = 1'b1;
          oval_nxt  = dy_r[32] ? (y0_r - md_quo[31:0]) : (y0_r + md_quo[31:0]);
          ost_nxt   = ST_INTERP;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    dy_r   <= dy_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = ov_r;
  assign out_value  = oval_r;
  assign out_status = ost_r;

endmodule

// ----- sv/stli_checker.sv -----
// ----------------------------------------------------------------------------
// stli_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_linear_interpolator_macros.svh"

module stli_checker
  import stli_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_value,
  input logic [2:0]  out_status
);

  // An accepted item keeps the block busy in the next cycle.
  `STLI_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // A result appears exactly when the block goes idle.
  `STLI_ASSERT_IMP(a_fall_result, clk, rst_n, $fell(busy), out_valid)
  // One result per item: each out_valid strobe is followed by a low out_valid.
  `STLI_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // Value is zero unless the status carries a y value.
  `STLI_ASSERT_IMP(a_zero_value, clk, rst_n,
    out_valid && out_status != ST_MATCH && out_status != ST_INTERP, out_value == 32'd0)

endmodule

bind sorted_table_linear_interpolator stli_checker u_stli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_value (out_value),
  .out_status(out_status)
);
